### design/exec_hunk_data_locator_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the executable hunk data locator
// Shared property forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef EXEC_HUNK_DATA_LOCATOR_CORE_DEFINES_SVH
`define EXEC_HUNK_DATA_LOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define EHDL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define EHDL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define EHDL_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ehdl_pkg.sv
// ---------------------------------------------------------------------------
// Executable hunk data locator package
// Types, hunk type codes and status codes shared by the locator files.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ehdl_pkg;

  localparam logic [31:0] MAGIC_HEADER = 32'h0000_03F3;
  localparam logic [31:0] TYPE_DATA    = 32'h0000_03EA;
  localparam logic [31:0] TYPE_CODE    = 32'h0000_03E9;
  localparam logic [31:0] TYPE_DREL32  = 32'h0000_03F7;
  localparam logic [31:0] TYPE_END     = 32'h0000_03F2;
  localparam logic [31:0] TABLE_BASE   = 32'h0000_0014;
  localparam logic [31:0] COUNT_POS    = 32'h0000_0008;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NOT_EXEC     = 3'd1,
    ST_DATA_RELOC   = 3'd2,
    ST_UNKNOWN_HUNK = 3'd3,
    ST_NO_DATA      = 3'd4,
    ST_TRUNCATED    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    PH_MAGIC  = 3'd0,
    PH_COUNT  = 3'd1,
    PH_TYPE   = 3'd2,
    PH_LENGTH = 3'd3,
    PH_RELOC  = 3'd4
  } phase_t;

endpackage

### design/ehdl_if.sv
// ---------------------------------------------------------------------------
// Executable hunk data locator channels
// Valid/ready channels for the byte stream and for the status result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ehdl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ehdl_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] data_hunk_offset;
  logic [31:0] data_hunk_bytes;

  modport source (output valid, output status, output data_hunk_offset,
                  output data_hunk_bytes, input ready);
  modport sink (input valid, input status, input data_hunk_offset,
                input data_hunk_bytes, output ready);
endinterface

### design/exec_hunk_data_locator_core.sv
// ---------------------------------------------------------------------------
// Executable hunk data locator
// Walks a hunk-format executable byte by byte and reports its first DATA hunk.
// ---------------------------------------------------------------------------
// The block takes one file byte per clock cycle and never stalls the byte
// stream except while a finished status beat waits at the output; each byte
// updates the position, the four-byte shift word and the parse phase, and the
// status beat appears in the output register on the cycle after the byte that
// ends the walk, raises an error, or carries last_byte without an earlier
// result. Bytes after a result are consumed and ignored until last_byte,
// after which the parser rearms for the next file.
// There is no memory and no clearing pass after reset.
`timescale 1ns / 1ps

module exec_hunk_data_locator_core (
  input  logic                 clk,
  input  logic                 rst,
  ehdl_byte_if.sink            byte_stream,
  ehdl_result_if.source        result
);

  logic [31:0]          byte_position, byte_position_next;
  logic [31:0]          word_shift, word_shift_next;
  ehdl_pkg::phase_t     parse_phase, parse_phase_next;
  logic [31:0]          hunks_left, hunks_left_next;
  logic [31:0]          next_field_position, next_field_position_next;
  logic [31:0]          found_offset, found_offset_next;
  logic [31:0]          found_bytes, found_bytes_next;
  logic                 inside_data_hunk, inside_data_hunk_next;
  logic                 result_sent, result_sent_next;
  logic                 pending_is_data, pending_is_data_next;

  logic                 res_valid;
  ehdl_pkg::status_t    res_status;
  logic [31:0]          res_offset;
  logic [31:0]          res_bytes;

  logic                 accept;
  logic                 emit;
  ehdl_pkg::status_t    emit_status;
  logic [31:0]          emit_offset;
  logic [31:0]          emit_bytes;
  logic [31:0]          w;
  logic                 long_done;
  logic                 short_done;
  logic [31:0]          reloc_pad;

  // Output side: the result register frees up when its beat is taken.
  always_comb begin
    byte_stream.ready       = !res_valid || result.ready;
    result.valid            = res_valid;
    result.status           = res_status;
    result.data_hunk_offset = res_offset;
    result.data_hunk_bytes  = res_bytes;
  end

  assign accept     = byte_stream.valid && byte_stream.ready;
  assign w          = {word_shift[23:0], byte_stream.data_byte};
  assign long_done  = (byte_position == next_field_position + 32'd3);
  assign short_done = (byte_position == next_field_position + 32'd1);
  // After the list terminator the next type word sits on a longword boundary.
  assign reloc_pad  = (next_field_position[1:0] == 2'b10) ?
                      next_field_position + 32'd2 : next_field_position + 32'd4;

  always_comb begin
    byte_position_next       = byte_position;
    word_shift_next          = word_shift;
    parse_phase_next         = parse_phase;
    hunks_left_next          = hunks_left;
    next_field_position_next = next_field_position;
    found_offset_next        = found_offset;
    found_bytes_next         = found_bytes;
    inside_data_hunk_next    = inside_data_hunk;
    result_sent_next         = result_sent;
    pending_is_data_next     = pending_is_data;
    emit                     = 1'b0;
    emit_status              = ehdl_pkg::ST_OK;

    if (accept) begin
      word_shift_next    = w;
      byte_position_next = byte_position + 32'd1;

      if (!result_sent) begin
        unique case (parse_phase)
          ehdl_pkg::PH_MAGIC: begin
            if (long_done) begin
              if (w != ehdl_pkg::MAGIC_HEADER) begin
                emit        = 1'b1;
                emit_status = ehdl_pkg::ST_NOT_EXEC;
              end else begin
                parse_phase_next         = ehdl_pkg::PH_COUNT;
                next_field_position_next = ehdl_pkg::COUNT_POS;
              end
            end
          end
          ehdl_pkg::PH_COUNT: begin
            if (long_done) begin
              hunks_left_next = w;
              if (w == 32'd0) begin
                emit        = 1'b1;
                emit_status = ehdl_pkg::ST_NO_DATA;
              end else begin
                next_field_position_next = {w[29:0], 2'b00} + ehdl_pkg::TABLE_BASE;
                parse_phase_next         = ehdl_pkg::PH_TYPE;
              end
            end
          end
          ehdl_pkg::PH_TYPE: begin
            if (long_done) begin
              if (w == ehdl_pkg::TYPE_DATA || w == ehdl_pkg::TYPE_CODE) begin
                pending_is_data_next = 1'b0;
                if (w == ehdl_pkg::TYPE_DATA && found_offset == 32'd0) begin
                  found_offset_next     = next_field_position;
                  inside_data_hunk_next = 1'b1;
                  pending_is_data_next  = 1'b1;
                end
                next_field_position_next = next_field_position + 32'd4;
                parse_phase_next         = ehdl_pkg::PH_LENGTH;
              end else if (w == ehdl_pkg::TYPE_DREL32) begin
                if (inside_data_hunk) begin
                  emit        = 1'b1;
                  emit_status = ehdl_pkg::ST_DATA_RELOC;
                end else begin
                  next_field_position_next = next_field_position + 32'd4;
                  parse_phase_next         = ehdl_pkg::PH_RELOC;
                end
              end else if (w == ehdl_pkg::TYPE_END) begin
                next_field_position_next = next_field_position + 32'd4;
                inside_data_hunk_next    = 1'b0;
                hunks_left_next          = hunks_left - 32'd1;
                if (hunks_left == 32'd1) begin
                  emit        = 1'b1;
                  emit_status = (found_offset == 32'd0) ? ehdl_pkg::ST_NO_DATA
                                                        : ehdl_pkg::ST_OK;
                end
              end else begin
                emit        = 1'b1;
                emit_status = ehdl_pkg::ST_UNKNOWN_HUNK;
              end
            end
          end
          ehdl_pkg::PH_LENGTH: begin
            if (long_done) begin
              if (pending_is_data) begin
                found_bytes_next     = {w[29:0], 2'b00};
                pending_is_data_next = 1'b0;
              end
              next_field_position_next = next_field_position + 32'd4 +
                                         {w[29:0], 2'b00};
              parse_phase_next         = ehdl_pkg::PH_TYPE;
            end
          end
          ehdl_pkg::PH_RELOC: begin
            if (short_done) begin
              if (w[15:0] != 16'd0) begin
                next_field_position_next = next_field_position +
                                           {15'd0, w[15:0], 1'b0} + 32'd4;
              end else begin
                next_field_position_next = reloc_pad;
                parse_phase_next         = ehdl_pkg::PH_TYPE;
              end
            end
          end
          default: begin
            parse_phase_next = ehdl_pkg::PH_MAGIC;
          end
        endcase
      end

      if (emit) begin
        result_sent_next = 1'b1;
      end

      if (byte_stream.last_byte && !result_sent && !emit) begin
        emit        = 1'b1;
        emit_status = ehdl_pkg::ST_TRUNCATED;
      end
    end

    // The beat reports what was found up to and including this byte.
    emit_offset = found_offset_next;
    emit_bytes  = found_bytes_next;

    if (accept && byte_stream.last_byte) begin
      byte_position_next       = 32'd0;
      word_shift_next          = 32'd0;
      parse_phase_next         = ehdl_pkg::PH_MAGIC;
      hunks_left_next          = 32'd0;
      next_field_position_next = 32'd0;
      found_offset_next        = 32'd0;
      found_bytes_next         = 32'd0;
      inside_data_hunk_next    = 1'b0;
      result_sent_next         = 1'b0;
      pending_is_data_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position       <= 32'd0;
      word_shift          <= 32'd0;
      parse_phase         <= ehdl_pkg::PH_MAGIC;
      hunks_left          <= 32'd0;
      next_field_position <= 32'd0;
      found_offset        <= 32'd0;
      found_bytes         <= 32'd0;
      inside_data_hunk    <= 1'b0;
      result_sent         <= 1'b0;
      pending_is_data     <= 1'b0;
    end else begin
      byte_position       <= byte_position_next;
      word_shift          <= word_shift_next;
      parse_phase         <= parse_phase_next;
      hunks_left          <= hunks_left_next;
      next_field_position <= next_field_position_next;
      found_offset        <= found_offset_next;
      found_bytes         <= found_bytes_next;
      inside_data_hunk    <= inside_data_hunk_next;
      result_sent         <= result_sent_next;
      pending_is_data     <= pending_is_data_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_status <= emit_status;
      res_offset <= emit_offset;
      res_bytes  <= emit_bytes;
    end
  end

endmodule

### design/ehdl_checker.sv
// ---------------------------------------------------------------------------
// Executable hunk data locator port checker
// Watches the byte and result channels of the locator over time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "exec_hunk_data_locator_core_defines.svh"

module ehdl_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        res_valid,
  input logic        res_ready,
  input logic [2:0]  res_status,
  input logic [31:0] res_offset,
  input logic [31:0] res_bytes
);

  // The byte stream only waits behind a status beat that is not yet taken.
  `EHDL_ASSERT_NOW(a_ready_when_free, !res_valid || res_ready, in_ready, "byte stream stalled with a free output")

  // A new status beat only follows an accepted byte.
  `EHDL_ASSERT_NEXT(a_beat_needs_byte, !res_valid && !(in_valid && in_ready), !res_valid, "status beat without an accepted byte")

  // A held beat keeps its payload.
  `EHDL_ASSERT_NEXT(a_beat_holds, res_valid && !res_ready, res_valid && $stable(res_status) && $stable(res_offset) && $stable(res_bytes), "status beat changed while stalled")

  // Reset leaves no beat pending.
  `EHDL_ASSERT_NEXT_ALWAYS(a_reset_clears, rst, !res_valid, "status beat present after reset")

endmodule

bind exec_hunk_data_locator_core ehdl_checker u_ehdl_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (byte_stream.valid),
  .in_ready   (byte_stream.ready),
  .in_last    (byte_stream.last_byte),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_status (result.status),
  .res_offset (result.data_hunk_offset),
  .res_bytes  (result.data_hunk_bytes)
);

### sim/tb.sv
// ---------------------------------------------------------------------------
// Executable hunk data locator testbench
// Streams hunk-format files through the locator, byte by byte. It predicts
// each status beat with a model of the hunk walk, kept in step with every
// accepted byte, and compares each field of every result beat. Both sides
// of the block idle at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_BYTES = 900;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } file_byte_t;

  typedef struct packed {
    ehdl_pkg::status_t status;
    logic [31:0]       offset;
    logic [31:0]       length;
  } status_beat_t;

  logic clk = 1'b0;
  logic rst;

  ehdl_byte_if   byte_bus ();
  ehdl_result_if stat_bus ();

  exec_hunk_data_locator_core dut (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_bus),
    .result      (stat_bus)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // File bytes waiting for the driver, the file under construction, and the
  // status beats predicted but not yet seen.
  file_byte_t   byte_backlog[$];
  logic [7:0]   file_buf[$];
  status_beat_t status_due[$];

  int   fail_count = 0;
  int   beats_in = 0;
  int   cycle_count = 0;
  logic byte_took = 1'b0;

  // Hunk walk state of the predictor.
  logic [31:0]      scan_pos;
  logic [31:0]      shift_word;
  ehdl_pkg::phase_t scan_phase;
  logic [31:0]      hunks_open;
  logic [31:0]      field_pos;
  logic [31:0]      data_off;
  logic [31:0]      data_len;
  logic             in_data;
  logic             pend_data;
  logic             report_sent;

  function automatic void rearm();
    scan_pos    = '0;
    shift_word  = '0;
    scan_phase  = ehdl_pkg::PH_MAGIC;
    hunks_open  = '0;
    field_pos   = '0;
    data_off    = '0;
    data_len    = '0;
    in_data     = 1'b0;
    pend_data   = 1'b0;
    report_sent = 1'b0;
  endfunction

  function automatic void report(input ehdl_pkg::status_t st, output logic hit,
                                 output status_beat_t res);
    res.status  = st;
    res.offset  = data_off;
    res.length  = data_len;
    hit         = 1'b1;
    report_sent = 1'b1;
  endfunction

  function automatic void walk_byte(input logic [7:0] b, input logic fin,
                                    output logic hit, output status_beat_t res);
    logic [31:0] p;
    logic [31:0] nfp;
    logic [31:0] w;
    logic [31:0] q;
    logic [31:0] cnt;
    logic        long_done;
    logic        short_done;
    p   = scan_pos;
    nfp = field_pos;
    hit = 1'b0;
    res = '0;
    shift_word = {shift_word[23:0], b};
    w = shift_word;
    if (!report_sent) begin
      long_done  = (p == nfp + 32'd3);
      short_done = (p == nfp + 32'd1);
      case (scan_phase)
        ehdl_pkg::PH_MAGIC: begin
          if (long_done) begin
            if (w != ehdl_pkg::MAGIC_HEADER) begin
              report(ehdl_pkg::ST_NOT_EXEC, hit, res);
            end else begin
              scan_phase = ehdl_pkg::PH_COUNT;
              field_pos  = ehdl_pkg::COUNT_POS;
            end
          end
        end
        ehdl_pkg::PH_COUNT: begin
          if (long_done) begin
            hunks_open = w;
            if (w == 32'd0) begin
              report(ehdl_pkg::ST_NO_DATA, hit, res);
            end else begin
              field_pos  = (w << 2) + ehdl_pkg::TABLE_BASE;
              scan_phase = ehdl_pkg::PH_TYPE;
            end
          end
        end
        ehdl_pkg::PH_TYPE: begin
          if (long_done) begin
            if (w == ehdl_pkg::TYPE_DATA || w == ehdl_pkg::TYPE_CODE) begin
              pend_data = 1'b0;
              if (w == ehdl_pkg::TYPE_DATA && data_off == 32'd0) begin
                data_off  = nfp;
                in_data   = 1'b1;
                pend_data = 1'b1;
              end
              field_pos  = nfp + 32'd4;
              scan_phase = ehdl_pkg::PH_LENGTH;
            end else if (w == ehdl_pkg::TYPE_DREL32) begin
              if (in_data) begin
                report(ehdl_pkg::ST_DATA_RELOC, hit, res);
              end else begin
                field_pos  = nfp + 32'd4;
                scan_phase = ehdl_pkg::PH_RELOC;
              end
            end else if (w == ehdl_pkg::TYPE_END) begin
              field_pos  = nfp + 32'd4;
              in_data    = 1'b0;
              hunks_open = hunks_open - 32'd1;
              if (hunks_open == 32'd0) begin
                report((data_off == 32'd0) ? ehdl_pkg::ST_NO_DATA : ehdl_pkg::ST_OK,
                       hit, res);
              end
            end else begin
              report(ehdl_pkg::ST_UNKNOWN_HUNK, hit, res);
            end
          end
        end
        ehdl_pkg::PH_LENGTH: begin
          if (long_done) begin
            if (pend_data) begin
              data_len  = w << 2;
              pend_data = 1'b0;
            end
            field_pos  = nfp + 32'd4 + (w << 2);
            scan_phase = ehdl_pkg::PH_TYPE;
          end
        end
        ehdl_pkg::PH_RELOC: begin
          if (short_done) begin
            cnt = {16'd0, w[15:0]};
            if (cnt != 32'd0) begin
              field_pos = nfp + (cnt << 1) + 32'd4;
            end else begin
              // A zero count closes the list; the next type word sits on a
              // longword boundary.
              q = nfp + 32'd2;
              if (q[1:0] != 2'd0) begin
                q = q + 32'd2;
              end
              field_pos  = q;
              scan_phase = ehdl_pkg::PH_TYPE;
            end
          end
        end
        default: begin
          scan_phase = ehdl_pkg::PH_MAGIC;
        end
      endcase
    end
    scan_pos = p + 32'd1;
    if (fin) begin
      if (!report_sent) begin
        report(ehdl_pkg::ST_TRUNCATED, hit, res);
      end
      rearm();
    end
  endfunction

  // File building.
  task automatic add_long(input logic [31:0] v);
    file_buf.push_back(v[31:24]);
    file_buf.push_back(v[23:16]);
    file_buf.push_back(v[15:8]);
    file_buf.push_back(v[7:0]);
  endtask

  task automatic add_short(input logic [15:0] v);
    file_buf.push_back(v[15:8]);
    file_buf.push_back(v[7:0]);
  endtask

  task automatic add_noise(input int n);
    repeat (n) file_buf.push_back(8'($urandom));
  endtask

  task automatic add_header(input logic [31:0] count, input int table_words);
    add_long(ehdl_pkg::MAGIC_HEADER);
    add_noise(4);
    add_long(count);
    add_noise(8 + 4 * table_words);
  endtask

  task automatic add_body(input logic [31:0] kind, input logic [31:0] words);
    add_long(kind);
    add_long(words);
    add_noise(4 * int'(words));
  endtask

  task automatic add_reloc(input int groups);
    int c;
    add_long(ehdl_pkg::TYPE_DREL32);
    repeat (groups) begin
      c = $urandom_range(1, 3);
      add_short(16'(c));
      add_noise(2 + 2 * c);
    end
    add_short(16'd0);
    while (file_buf.size() % 4 != 0) file_buf.push_back(8'h00);
  endtask

  // Moves the file into the backlog, cut after keep bytes when keep is set,
  // and marks its final byte.
  task automatic ship_file(input int keep);
    int n;
    file_byte_t fb;
    if (file_buf.size() == 0) begin
      file_buf.push_back(8'($urandom));
    end
    n = (keep > 0 && keep < file_buf.size()) ? keep : file_buf.size();
    for (int i = 0; i < n; i++) begin
      fb.data = file_buf[i];
      fb.last = (i == n - 1);
      byte_backlog.push_back(fb);
    end
    file_buf.delete();
  endtask

  task automatic build_directed();
    // A file of one byte ends before the magic word.
    file_buf.push_back(8'hFF);
    ship_file(0);
    // Wrong magic, then bytes that must be ignored.
    add_long(32'hFFFF_FFFF);
    add_long(32'h0000_0000);
    ship_file(0);
    // Zero hunk count.
    add_header(32'd0, 0);
    add_noise(2);
    ship_file(0);
    // Code, then data: a clean walk.
    add_header(32'd2, 2);
    add_body(ehdl_pkg::TYPE_CODE, 32'd1);
    add_long(ehdl_pkg::TYPE_END);
    add_body(ehdl_pkg::TYPE_DATA, 32'd2);
    add_long(ehdl_pkg::TYPE_END);
    ship_file(0);
    // Code with an empty relocation list, no data anywhere.
    add_header(32'd1, 1);
    add_body(ehdl_pkg::TYPE_CODE, 32'd0);
    add_reloc(0);
    add_long(ehdl_pkg::TYPE_END);
    ship_file(0);
    // Relocation inside the data hunk.
    add_header(32'd1, 1);
    add_body(ehdl_pkg::TYPE_DATA, 32'd1);
    add_reloc(1);
    add_long(ehdl_pkg::TYPE_END);
    ship_file(0);
    // Relocated code, then two data hunks; only the first one counts.
    add_header(32'd3, 3);
    add_body(ehdl_pkg::TYPE_CODE, 32'd1);
    add_reloc(2);
    add_long(ehdl_pkg::TYPE_END);
    add_body(ehdl_pkg::TYPE_DATA, 32'd0);
    add_long(ehdl_pkg::TYPE_END);
    add_body(ehdl_pkg::TYPE_DATA, 32'd3);
    add_long(ehdl_pkg::TYPE_END);
    add_noise(3);
    ship_file(0);
    // Unknown hunk type.
    add_header(32'd1, 1);
    add_long(32'h0000_03F0);
    add_noise(4);
    ship_file(0);
    // Good file cut short inside its data hunk.
    add_header(32'd1, 1);
    add_body(ehdl_pkg::TYPE_DATA, 32'd3);
    add_long(ehdl_pkg::TYPE_END);
    ship_file(file_buf.size() - 7);
    // The hunk table skip wraps to a point behind the count.
    add_long(ehdl_pkg::MAGIC_HEADER);
    add_noise(4);
    add_long(32'h3FFF_FFFC);
    add_noise(12);
    ship_file(0);
    // Largest data length: the skip wraps back onto the length field.
    add_header(32'd1, 1);
    add_long(ehdl_pkg::TYPE_DATA);
    add_long(32'hFFFF_FFFF);
    add_noise(8);
    ship_file(0);
    // A count whose table skip wraps to nothing leaves many hunks open.
    add_long(ehdl_pkg::MAGIC_HEADER);
    add_noise(4);
    add_long(32'hC000_0000);
    add_noise(8);
    add_body(ehdl_pkg::TYPE_CODE, 32'd0);
    add_long(ehdl_pkg::TYPE_END);
    add_noise(4);
    ship_file(0);
    // A lone END closes the walk on the final byte of the file.
    add_header(32'd1, 1);
    add_long(ehdl_pkg::TYPE_END);
    ship_file(0);
  endtask

  task automatic build_random_file();
    int pick;
    int hunks;
    int keep;
    logic [31:0] kind;
    pick = $urandom_range(0, 99);
    keep = 0;
    if (pick < 72) begin
      hunks = $urandom_range(1, 3);
      add_header(32'(hunks), hunks);
      repeat (hunks) begin
        kind = ($urandom_range(0, 1) == 0) ? ehdl_pkg::TYPE_CODE : ehdl_pkg::TYPE_DATA;
        if ($urandom_range(0, 5) != 0) begin
          add_body(kind, 32'($urandom_range(0, 3)));
        end
        if ($urandom_range(0, 3) == 0) begin
          add_reloc($urandom_range(0, 2));
        end
        add_long(ehdl_pkg::TYPE_END);
      end
      if ($urandom_range(0, 1) == 0) begin
        add_noise($urandom_range(1, 6));
      end
      if ($urandom_range(0, 9) == 0) begin
        keep = $urandom_range(1, file_buf.size());
      end
    end else if (pick < 80) begin
      add_noise($urandom_range(1, 12));
    end else if (pick < 88) begin
      hunks = $urandom_range(1, 2);
      add_header(32'(hunks), hunks);
      if ($urandom_range(0, 1) == 0) begin
        add_body(ehdl_pkg::TYPE_CODE, 32'($urandom_range(0, 2)));
      end
      add_long($urandom());
      add_noise(4);
    end else if (pick < 94) begin
      add_long(ehdl_pkg::MAGIC_HEADER);
      add_noise(4);
      add_long($urandom());
      add_noise($urandom_range(8, 40));
    end else begin
      add_header(32'd0, 0);
      add_noise($urandom_range(0, 4));
    end
    ship_file(keep);
  endtask

  // Sender: bursts of random length separated by random gaps.
  int gap_left = 0;
  int burst_left = 0;

  always @(negedge clk) begin : driver
    if (rst) begin
      byte_bus.valid <= 1'b0;
    end else if (byte_bus.valid && !byte_took) begin
      // The beat on offer has not been taken yet, so it stays on the bus.
    end else if (gap_left > 0) begin
      byte_bus.valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (byte_backlog.size() > 0) begin
      byte_bus.valid     <= 1'b1;
      byte_bus.data_byte <= byte_backlog[0].data;
      byte_bus.last_byte <= byte_backlog[0].last;
      if (burst_left > 1) begin
        burst_left <= burst_left - 1;
      end else begin
        burst_left <= $urandom_range(1, 40);
        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end
    end else begin
      byte_bus.valid <= 1'b0;
    end
  end

  // Receiver: a randomly redrawn stall mode, plus one long hold-off while a
  // status beat waits, so the block has to stall the byte stream.
  int   stall_mode = 0;
  int   rcv_tick = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;

  always @(negedge clk) begin : receiver
    logic rdy;
    if (rst) begin
      rdy = 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rdy = 1'b0;
    end else if (!hold_done && stat_bus.valid && beats_in >= 300) begin
      hold_left = 250;
      hold_done = 1'b1;
      rdy = 1'b0;
    end else begin
      if (rcv_tick % 64 == 0) begin
        stall_mode = $urandom_range(0, 3);
      end
      case (stall_mode)
        0: rdy = 1'b1;
        1: rdy = 1'($urandom_range(0, 1));
        2: rdy = ($urandom_range(0, 3) != 0);
        default: rdy = (rcv_tick % 7 == 0);
      endcase
      rcv_tick = rcv_tick + 1;
    end
    stat_bus.ready <= rdy;
  end

  always @(posedge clk) begin : monitor
    status_beat_t fresh;
    status_beat_t want;
    logic         hit;
    byte_took <= !rst && byte_bus.valid && byte_bus.ready;
    if (!rst && byte_bus.valid && byte_bus.ready) begin
      walk_byte(byte_bus.data_byte, byte_bus.last_byte, hit, fresh);
      if (hit) begin
        status_due.push_back(fresh);
      end
      void'(byte_backlog.pop_front());
      beats_in = beats_in + 1;
    end
    if (!rst && stat_bus.valid && stat_bus.ready) begin
      if (status_due.size() == 0) begin
        $display("%0t: status beat %0d/%h/%h arrived with none due", $time,
                 stat_bus.status, stat_bus.data_hunk_offset, stat_bus.data_hunk_bytes);
        fail_count = fail_count + 1;
      end else begin
        want = status_due.pop_front();
        if (stat_bus.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status,
                   stat_bus.status);
          fail_count = fail_count + 1;
        end
        if (stat_bus.data_hunk_offset !== want.offset) begin
          $display("%0t: data_hunk_offset expected %h got %h", $time, want.offset,
                   stat_bus.data_hunk_offset);
          fail_count = fail_count + 1;
        end
        if (stat_bus.data_hunk_bytes !== want.length) begin
          $display("%0t: data_hunk_bytes expected %h got %h", $time, want.length,
                   stat_bus.data_hunk_bytes);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    int random_start;
    rst = 1'b1;
    byte_bus.valid     = 1'b0;
    byte_bus.data_byte = 8'h00;
    byte_bus.last_byte = 1'b0;
    stat_bus.ready     = 1'b0;
    rearm();
    build_directed();
    random_start = byte_backlog.size();
    while (byte_backlog.size() - random_start < RANDOM_BYTES) build_random_file();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait (byte_backlog.size() == 0);
    wait (status_due.size() == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
